[hdl/stbe_pkg.sv]
// ----------------------------------------------------------------------------
// stbe_pkg
// Opcodes, status codes, sequencer states and defaults shared by the
// stack bytecode execute unit.
// ----------------------------------------------------------------------------
package stbe_pkg;

  localparam int MEM_WORDS_DEF  = 4096;
  localparam int CODE_WORDS_DEF = 65536;

  typedef enum logic [5:0] {
    OP_LEA  = 6'd0,  OP_IMM  = 6'd1,  OP_JMP  = 6'd2,  OP_JSR  = 6'd3,
    OP_BZ   = 6'd4,  OP_BNZ  = 6'd5,  OP_ENT  = 6'd6,  OP_ADJ  = 6'd7,
    OP_LEV  = 6'd8,  OP_LI   = 6'd9,  OP_LC   = 6'd10, OP_SI   = 6'd11,
    OP_SC   = 6'd12, OP_PSH  = 6'd13, OP_OR   = 6'd14, OP_XOR  = 6'd15,
    OP_AND  = 6'd16, OP_EQ   = 6'd17, OP_NE   = 6'd18, OP_LT   = 6'd19,
    OP_GT   = 6'd20, OP_LE   = 6'd21, OP_GE   = 6'd22, OP_SHL  = 6'd23,
    OP_SHR  = 6'd24, OP_ADD  = 6'd25, OP_SUB  = 6'd26, OP_MUL  = 6'd27,
    OP_DIV  = 6'd28, OP_MOD  = 6'd29, OP_OPEN = 6'd30, OP_READ = 6'd31,
    OP_CLOS = 6'd32, OP_PRTF = 6'd33, OP_MALC = 6'd34, OP_FREE = 6'd35,
    OP_MSET = 6'd36, OP_MCMP = 6'd37, OP_EXIT = 6'd38
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_HALTED = 3'd1,
    ST_UNSUP  = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_DIVZERO = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_EX1, S_EX2, S_MUL, S_DIV, S_DONE
  } state_t;

endpackage

[hdl/stack_bytecode_execute_unit_top.sv]
// ----------------------------------------------------------------------------
// stack_bytecode_execute_unit_top
// Executes one stack-machine instruction per input beat against a word
// memory holding data and stack.
// ----------------------------------------------------------------------------
//  channel   dir  signals                       content
//  s_axis    in   s_tvalid s_tready s_tdata     opcode, operand
//  m_axis    out  m_tvalid m_tready m_tdata     next_pc .. exit_code
//  cfg       in   cfg_valid cfg_ready cfg_data  entry_address
//
//  Register-only ops need no memory read, others wait on one word read, LEV
//  and SC on a second access; MUL makes four passes over a 32x32 multiplier,
//  DIV/MOD runs the one-bit-per-cycle divider. The single memory port serialises the rest.
//  After reset a clearing pass zeroes every memory word;
//  no instruction is taken meanwhile, configuration writes are.
//  A result waits in the output register; a stalled output holds the
//  sequencer in its final state.
// ----------------------------------------------------------------------------
module stack_bytecode_execute_unit_top
  import stbe_pkg::*;
#(
  parameter int MEM_WORDS  = MEM_WORDS_DEF,
  parameter int CODE_WORDS = CODE_WORDS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [71:0]  s_tdata,   // opcode[5:0], operand[69:6], zero pad
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [183:0] m_tdata,   // next_pc[15:0], accumulator[79:16],
                                  // stack_pointer[95:80], frame_pointer[111:96],
                                  // status[114:112], exit_code[178:115], pad
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data
);

  localparam int AW = $clog2(MEM_WORDS);
  localparam logic [15:0] MEM_BYTES = 16'((MEM_WORDS * 8) % 65536);
  localparam logic [15:0] CODE_MASK = 16'(CODE_WORDS - 1);

  function automatic logic [AW-1:0] widx(input logic [15:0] a);
    logic [15:0] w;
    w = {3'b000, a[15:3]};
    return w[AW-1:0];
  endfunction

  function automatic logic [15:0] ca(input logic [15:0] v);
    return v & CODE_MASK;
  endfunction

  state_t state, state_next;

  logic [63:0] mem [MEM_WORDS];
  logic [63:0] rdata;
  logic        wr_en;
  logic [AW-1:0] wr_idx, rd_idx, clr_idx;
  logic [63:0] wr_data;

  logic [63:0] acc, x;
  logic [15:0] sp, fp, pc;
  logic        halted;
  opcode_t     op;
  status_t     status;
  logic [63:0] exit_val;

  logic [63:0] o_acc, o_exit;
  logic [15:0] o_pc, o_sp, o_fp;
  status_t     o_status;

  logic [1:0]  mstep;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod, macc;

  logic        div_start, div_done;
  logic [63:0] div_q, div_r;

  opcode_t     in_op;
  logic [63:0] in_opnd;
  logic        accept, out_free;
  logic [15:0] pc1, pc2;
  logic [5:0]  bsh;
  logic [7:0]  lbyte, sbyte;
  logic [63:0] alu;

  assign in_op    = opcode_t'(s_tdata[5:0]);
  assign in_opnd  = s_tdata[69:6];
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign pc1      = ca(pc + 16'd1);
  assign pc2      = ca(pc + 16'd2);
  assign cfg_ready = 1'b1;

  // the popped word is on the read port while the divider starts
  stbe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rdata),
    .divisor  (acc),
    .done     (div_done),
    .quo      (div_q),
    .rem      (div_r)
  );

  // memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= wr_data;
    rdata <= mem[rd_idx];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_idx == AW'(MEM_WORDS - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (halted) begin
            state_next = S_EX1;
          end else begin
            case (in_op)
              OP_LEV, OP_LI, OP_LC, OP_SI, OP_SC, OP_OR, OP_XOR, OP_AND, OP_EQ,
              OP_NE, OP_LT, OP_GT, OP_LE, OP_GE, OP_SHL, OP_SHR, OP_ADD, OP_SUB,
              OP_MUL, OP_DIV, OP_MOD, OP_EXIT: state_next = S_EX1;
              default: state_next = S_DONE;
            endcase
          end
        end
      end
      S_EX1: begin
        if (halted || op == OP_EXIT) state_next = S_DONE;
        else begin
          case (op)
            OP_LEV, OP_SC: state_next = S_EX2;
            OP_MUL: state_next = S_MUL;
            OP_DIV, OP_MOD: state_next = (acc == 64'd0) ? S_DONE : S_DIV;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_EX2: state_next = S_DONE;
      S_MUL: if (mstep == 2'd3) state_next = S_DONE;
      S_DIV: if (div_done) state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory port, handshake and unit controls
  always_comb begin
    s_tready  = (state == S_IDLE);
    wr_en     = 1'b0;
    wr_idx    = widx(sp - 16'd8);
    wr_data   = acc;
    rd_idx    = widx(sp);
    div_start = 1'b0;
    bsh       = {acc[2:0], 3'b000};
    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_idx  = clr_idx;
        wr_data = '0;
      end
      S_IDLE: begin
        if (!halted) begin
          case (in_op)
            OP_JSR: begin
              wr_en   = accept;
              wr_data = {48'd0, pc2};
            end
            OP_ENT: begin
              wr_en   = accept;
              wr_data = {48'd0, fp};
            end
            OP_PSH: wr_en = accept;
            OP_LEV: rd_idx = widx(fp);
            OP_LI, OP_LC: rd_idx = widx(acc[15:0]);
            default: rd_idx = widx(sp);
          endcase
        end
      end
      S_EX1: begin
        if (!halted) begin
          case (op)
            OP_LEV: rd_idx = widx(sp + 16'd8);
            OP_SC: rd_idx = widx(rdata[15:0]);
            OP_SI: begin
              wr_en  = 1'b1;
              wr_idx = widx(rdata[15:0]);
            end
            OP_DIV, OP_MOD: div_start = (acc != 64'd0);
            default: rd_idx = widx(sp);
          endcase
        end
      end
      S_EX2: begin
        // merge the stored byte into the addressed word
        bsh = {x[2:0], 3'b000};
        if (op == OP_SC) begin
          wr_en   = 1'b1;
          wr_idx  = widx(x[15:0]);
          wr_data = (rdata & ~(64'hFF << bsh)) | ({56'd0, acc[7:0]} << bsh);
        end
      end
      default: ;
    endcase
  end

  assign lbyte = 8'(rdata >> bsh);
  assign sbyte = acc[7:0];

  // ALU on the popped word and the accumulator
  always_comb begin
    case (op)
      OP_OR:  alu = rdata | acc;
      OP_XOR: alu = rdata ^ acc;
      OP_AND: alu = rdata & acc;
      OP_EQ:  alu = {63'd0, rdata == acc};
      OP_NE:  alu = {63'd0, rdata != acc};
      OP_LT:  alu = {63'd0, $signed(rdata) < $signed(acc)};
      OP_GT:  alu = {63'd0, $signed(acc) < $signed(rdata)};
      OP_LE:  alu = {63'd0, !($signed(acc) < $signed(rdata))};
      OP_GE:  alu = {63'd0, !($signed(rdata) < $signed(acc))};
      OP_SHL: alu = rdata << acc[5:0];
      OP_SHR: alu = 64'($signed(rdata) >>> acc[5:0]);
      OP_ADD: alu = rdata + acc;
      OP_SUB: alu = rdata - acc;
      default: alu = acc;
    endcase
  end

  // partial-product operands for the low 64 bits of the product
  always_comb begin
    case (mstep)
      2'd0: begin mul_a = x[31:0];  mul_b = acc[31:0];  end
      2'd1: begin mul_a = x[31:0];  mul_b = acc[63:32]; end
      default: begin mul_a = x[63:32]; mul_b = acc[31:0]; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      acc     <= '0;
      sp      <= MEM_BYTES;
      fp      <= MEM_BYTES;
      pc      <= ca(16'd0);
      halted  <= 1'b0;
      m_tvalid <= 1'b0;
      mstep   <= '0;
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (cfg_valid) pc <= ca(cfg_data);
      case (state)
        S_CLEAR: clr_idx <= clr_idx + AW'(1);
        S_IDLE: begin
          if (accept) begin
            op       <= in_op;
            status   <= ST_OK;
            exit_val <= '0;
            mstep    <= '0;
            if (!halted) begin
              pc <= pc1;
              case (in_op)
                OP_LEA: begin
                  acc <= {48'd0, fp} + (in_opnd << 3);
                  pc  <= pc2;
                end
                OP_IMM: begin acc <= in_opnd; pc <= pc2; end
                OP_JMP: pc <= ca(in_opnd[15:0]);
                OP_JSR: begin sp <= sp - 16'd8; pc <= ca(in_opnd[15:0]); end
                OP_BZ:  pc <= (acc == 64'd0) ? ca(in_opnd[15:0]) : pc2;
                OP_BNZ: pc <= (acc != 64'd0) ? ca(in_opnd[15:0]) : pc2;
                OP_ENT: begin
                  fp <= sp - 16'd8;
                  sp <= sp - 16'd8 - {in_opnd[12:0], 3'b000};
                  pc <= pc2;
                end
                OP_ADJ: begin sp <= sp + {in_opnd[12:0], 3'b000}; pc <= pc2; end
                OP_LEV: sp <= fp;
                OP_LI, OP_LC, OP_EXIT: ;
                OP_PSH: sp <= sp - 16'd8;
                OP_OPEN, OP_READ, OP_CLOS, OP_PRTF, OP_MALC, OP_FREE, OP_MSET,
                OP_MCMP: status <= ST_UNSUP;
                OP_SI, OP_SC, OP_OR, OP_XOR, OP_AND, OP_EQ, OP_NE, OP_LT, OP_GT,
                OP_LE, OP_GE, OP_SHL, OP_SHR, OP_ADD, OP_SUB, OP_MUL, OP_DIV,
                OP_MOD: sp <= sp + 16'd8;
                default: status <= ST_UNKNOWN;
              endcase
            end
          end
        end
        S_EX1: begin
          x <= rdata;
          if (halted || op == OP_EXIT) begin
            status   <= ST_HALTED;
            exit_val <= rdata;
            halted   <= 1'b1;
          end else begin
            case (op)
              OP_LEV: fp <= rdata[15:0];
              OP_LI:  acc <= rdata;
              OP_LC:  acc <= {{56{lbyte[7]}}, lbyte};
              OP_MUL, OP_SI, OP_SC: ;
              OP_DIV, OP_MOD: if (acc == 64'd0) status <= ST_DIVZERO;
              default: acc <= alu;
            endcase
          end
        end
        S_EX2: begin
          if (op == OP_LEV) begin
            pc <= ca(rdata[15:0]);
            sp <= sp + 16'd16;
          end else begin
            acc <= {{56{sbyte[7]}}, sbyte};
          end
        end
        S_MUL: begin
          prod  <= mul_a * mul_b;
          mstep <= mstep + 2'd1;
          case (mstep)
            2'd1: macc <= prod;
            2'd2: macc <= macc + {prod[31:0], 32'd0};
            2'd3: acc  <= macc + {prod[31:0], 32'd0};
            default: ;
          endcase
        end
        S_DIV: if (div_done) acc <= (op == OP_DIV) ? div_q : div_r;
        S_DONE: begin
          if (out_free) begin
            o_pc     <= pc;
            o_acc    <= acc;
            o_sp     <= sp;
            o_fp     <= fp;
            o_status <= status;
            o_exit   <= exit_val;
          end
        end
        default: ;
      endcase
    end
  end

  assign m_tdata = {5'd0, o_exit, o_status, o_fp, o_sp, o_acc, o_pc};

endmodule

[hdl/stbe_div.sv]
// ----------------------------------------------------------------------------
// stbe_div
// Signed 64-bit divider, restoring, one quotient bit per cycle.
// Truncating quotient, remainder takes the dividend's sign.
// ----------------------------------------------------------------------------
module stbe_div
  import stbe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quo,
  output logic [63:0] rem
);

  logic        busy;
  logic [6:0]  cnt;
  logic [63:0] q;
  logic [63:0] r;
  logic [63:0] d;
  logic        neg_q;
  logic        neg_r;
  logic [64:0] trial;
  logic [64:0] diff;

  assign trial = {r, q[63]};
  assign diff  = trial - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= 7'd0;
        q     <= dividend[63] ? -dividend : dividend;
        d     <= divisor[63] ? -divisor : divisor;
        r     <= '0;
        neg_q <= dividend[63] ^ divisor[63];
        neg_r <= dividend[63];
      end else if (busy) begin
        // shift one dividend bit into the partial remainder
        if (!diff[64]) begin
          r <= diff[63:0];
          q <= {q[62:0], 1'b1};
        end else begin
          r <= trial[63:0];
          q <= {q[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = neg_q ? -q : q;
  assign rem = neg_r ? -r : r;

endmodule
